// ----- src/nfst_pkg.sv -----
// ----------------------------------------------------------------------------
// nfst_pkg: shared types and constants for the next-fit slot tracker
// Holds the table geometry, command and status codes, controller states and
// the request/status bundles exchanged with the handle table.
// ----------------------------------------------------------------------------
package nfst_pkg;

    // Table geometry.
    localparam int SLOT_COUNT  = 64;
    localparam int SLOT_W      = $clog2(SLOT_COUNT);
    localparam int CNT_W       = $clog2(SLOT_COUNT + 1);
    localparam int MAX_RESULTS = 64;

    // Field widths.
    localparam int HANDLE_W   = 32;
    localparam int SLOT_IN_W  = 8;
    localparam int SLOT_OUT_W = 6;

    // The all-ones handle is rejected by track and is never stored.
    localparam logic [HANDLE_W-1:0] EMPTY_HANDLE = '1;

    typedef enum logic [1:0] {
        CMD_TRACK       = 2'd0,
        CMD_FREE_SLOT   = 2'd1,
        CMD_FREE_HANDLE = 2'd2,
        CMD_LIST        = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_REJECT = 2'd1,
        ST_MISS   = 2'd2,
        ST_EMPTY  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_TRACK,
        S_FIND,
        S_LIST
    } state_t;

    // Request from the controller to the handle table.
    typedef struct packed {
        logic                rd_en;
        logic [SLOT_W-1:0]   rd_addr;
        logic                set_en;
        logic                clr_en;
        logic [SLOT_W-1:0]   wr_addr;
        logic [HANDLE_W-1:0] wr_data;
    } tbl_req_t;

    // Status returned by the handle table.
    typedef struct packed {
        logic [HANDLE_W-1:0]   rd_data;
        logic [SLOT_COUNT-1:0] valid;
        logic [CNT_W-1:0]      occ;
    } tbl_stat_t;

    // Next slot index, wrapping at the end of the table.
    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] idx);
        logic [SLOT_W-1:0] res;
        if (32'(idx) == SLOT_COUNT - 1) begin
            res = '0;
        end else begin
            res = idx + SLOT_W'(1);
        end
        return res;
    endfunction

endpackage

// ----- src/next_fit_slot_tracker_core.sv -----
// ----------------------------------------------------------------------------
// next_fit_slot_tracker_core: next-fit handle slot allocator
// Commands track, free by slot, free by handle and list over a 64-slot table.
// ----------------------------------------------------------------------------
// The block works on one command at a time. Free by slot, and any command
// that is rejected or finds the table empty, loads its result word when it
// is accepted, with no walk. Track walks the occupied flags from the
// next-fit pointer one slot per cycle after the accepting cycle, up to the
// first empty slot. Free by handle and list read the handle memory one slot
// per cycle from slot 0 through its registered read port. A result waiting
// in the output register that is not taken stalls the walk. Each command
// gives one result word, except list, which gives one word per occupied
// slot with tlast on the final one. Reset clears the occupied flags at
// once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module next_fit_slot_tracker_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // command[1:0], handle[33:2], slot[41:34], zero[47:42]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // status[1:0], slot_out[7:2], handle_out[39:8]
    output logic        m_tlast
);

    localparam int SW = nfst_pkg::SLOT_W;
    localparam int HW = nfst_pkg::HANDLE_W;

    // Input word fields.
    nfst_pkg::cmd_t                 cmd_in;
    logic [HW-1:0]                  handle_in;
    logic [nfst_pkg::SLOT_IN_W-1:0] slot_in;

    assign cmd_in    = nfst_pkg::cmd_t'(s_tdata[1:0]);
    assign handle_in = s_tdata[33:2];
    assign slot_in   = s_tdata[41:34];

    // Controller state.
    nfst_pkg::state_t           state_reg, state_next;
    logic [HW-1:0]              handle_reg, handle_next;
    logic [SW-1:0]              idx_reg, idx_next;
    logic [SW-1:0]              ptr_reg, ptr_next;
    logic [nfst_pkg::CNT_W-1:0] list_cnt_reg, list_cnt_next;

    // Output register.
    logic                            out_valid_reg;
    nfst_pkg::status_t               out_status_reg;
    logic [nfst_pkg::SLOT_OUT_W-1:0] out_slot_reg;
    logic [HW-1:0]                   out_handle_reg;
    logic                            out_last_reg;

    logic                            load;
    nfst_pkg::status_t               ld_status;
    logic [nfst_pkg::SLOT_OUT_W-1:0] ld_slot;
    logic [HW-1:0]                   ld_handle;
    logic                            ld_last;

    logic can_load;
    logic accept;
    logic hit;
    logic list_last;

    nfst_pkg::tbl_req_t  req;
    nfst_pkg::tbl_stat_t stat;

    nfst_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .stat    (stat)
    );

    assign can_load = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == nfst_pkg::S_IDLE) && can_load;
    assign accept   = s_tvalid && s_tready;

    // Find matches an occupied slot holding the handle; list takes any occupied slot.
    assign hit       = stat.valid[idx_reg] && (stat.rd_data == handle_reg);
    assign list_last = (list_cnt_reg == stat.occ - nfst_pkg::CNT_W'(1)) ||
                       (32'(list_cnt_reg) == nfst_pkg::MAX_RESULTS - 1);

    // Next state, table requests and result loads.
    always_comb begin
        state_next    = state_reg;
        handle_next   = handle_reg;
        idx_next      = idx_reg;
        ptr_next      = ptr_reg;
        list_cnt_next = list_cnt_reg;
        req           = '0;
        load          = 1'b0;
        ld_status     = nfst_pkg::ST_OK;
        ld_slot       = '0;
        ld_handle     = '0;
        ld_last       = 1'b1;

        unique case (state_reg)
            nfst_pkg::S_IDLE: begin
                if (accept) begin
                    handle_next = handle_in;
                    unique case (cmd_in)
                        nfst_pkg::CMD_TRACK: begin
                            if (handle_in == nfst_pkg::EMPTY_HANDLE ||
                                32'(stat.occ) == nfst_pkg::SLOT_COUNT) begin
                                load      = 1'b1;
                                ld_status = nfst_pkg::ST_REJECT;
                            end else begin
                                idx_next   = ptr_reg;
                                state_next = nfst_pkg::S_TRACK;
                            end
                        end
                        nfst_pkg::CMD_FREE_SLOT: begin
                            load = 1'b1;
                            if (32'(slot_in) >= nfst_pkg::SLOT_COUNT) begin
                                ld_status = nfst_pkg::ST_MISS;
                            end else begin
                                req.clr_en  = 1'b1;
                                req.wr_addr = SW'(slot_in);
                                ld_slot     = nfst_pkg::SLOT_OUT_W'(slot_in);
                            end
                        end
                        nfst_pkg::CMD_FREE_HANDLE: begin
                            if (handle_in == nfst_pkg::EMPTY_HANDLE || stat.occ == '0) begin
                                load      = 1'b1;
                                ld_status = nfst_pkg::ST_MISS;
                            end else begin
                                req.rd_en  = 1'b1;
                                req.rd_addr = '0;
                                idx_next   = '0;
                                state_next = nfst_pkg::S_FIND;
                            end
                        end
                        nfst_pkg::CMD_LIST: begin
                            if (stat.occ == '0) begin
                                load      = 1'b1;
                                ld_status = nfst_pkg::ST_EMPTY;
                            end else begin
                                req.rd_en     = 1'b1;
                                req.rd_addr   = '0;
                                idx_next      = '0;
                                list_cnt_next = '0;
                                state_next    = nfst_pkg::S_LIST;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // Walk the occupied flags from the pointer to the first empty slot.
            nfst_pkg::S_TRACK: begin
                if (!stat.valid[idx_reg]) begin
                    if (can_load) begin
                        req.set_en  = 1'b1;
                        req.wr_addr = idx_reg;
                        req.wr_data = handle_reg;
                        ptr_next    = nfst_pkg::slot_inc(idx_reg);
                        load        = 1'b1;
                        ld_slot     = nfst_pkg::SLOT_OUT_W'(idx_reg);
                        state_next  = nfst_pkg::S_IDLE;
                    end
                end else begin
                    idx_next = nfst_pkg::slot_inc(idx_reg);
                end
            end

            // Read slots in order until the handle turns up or the table ends.
            nfst_pkg::S_FIND: begin
                if (hit || 32'(idx_reg) == nfst_pkg::SLOT_COUNT - 1) begin
                    if (can_load) begin
                        load = 1'b1;
                        if (hit) begin
                            req.clr_en  = 1'b1;
                            req.wr_addr = idx_reg;
                            ld_slot     = nfst_pkg::SLOT_OUT_W'(idx_reg);
                        end else begin
                            ld_status = nfst_pkg::ST_MISS;
                        end
                        state_next = nfst_pkg::S_IDLE;
                    end
                end else begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = idx_reg + SW'(1);
                    idx_next    = idx_reg + SW'(1);
                end
            end

            // Read slots in order and emit one word per occupied slot.
            nfst_pkg::S_LIST: begin
                if (stat.valid[idx_reg]) begin
                    if (can_load) begin
                        load      = 1'b1;
                        ld_slot   = nfst_pkg::SLOT_OUT_W'(idx_reg);
                        ld_handle = stat.rd_data;
                        ld_last   = list_last;
                        if (list_last) begin
                            state_next = nfst_pkg::S_IDLE;
                        end else begin
                            req.rd_en     = 1'b1;
                            req.rd_addr   = idx_reg + SW'(1);
                            idx_next      = idx_reg + SW'(1);
                            list_cnt_next = list_cnt_reg + nfst_pkg::CNT_W'(1);
                        end
                    end
                end else begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = idx_reg + SW'(1);
                    idx_next    = idx_reg + SW'(1);
                end
            end

            default: begin
                state_next = nfst_pkg::S_IDLE;
            end
        endcase
    end

    // Controller registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= nfst_pkg::S_IDLE;
            ptr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        handle_reg   <= handle_next;
        idx_reg      <= idx_next;
        list_cnt_reg <= list_cnt_next;
    end

    // Output register: holds a word until the sink takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_status_reg <= ld_status;
            out_slot_reg   <= ld_slot;
            out_handle_reg <= ld_handle;
            out_last_reg   <= ld_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_handle_reg, out_slot_reg, out_status_reg};
    assign m_tlast  = out_last_reg;

    // Any result other than a success is a single word carrying no handle.
    a_fail_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_status_reg != nfst_pkg::ST_OK) |->
        (out_last_reg && out_handle_reg == '0))
        else $error("failure result is not a lone word");

    // A track walk only starts when an empty slot exists.
    a_track_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == nfst_pkg::S_TRACK) |->
        (32'(stat.occ) < nfst_pkg::SLOT_COUNT))
        else $error("track walk on a full table");

    // An accepted command either starts a walk or produces a word at once.
    a_accept_progress: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg != nfst_pkg::S_IDLE || out_valid_reg))
        else $error("accepted command made no progress");

endmodule

// ----- src/nfst_table.sv -----
// ----------------------------------------------------------------------------
// nfst_table: handle storage for the next-fit slot tracker
// A synchronous handle memory with a registered read port, a per-slot
// occupied flag vector cleared by reset, and a running occupancy count.
// ----------------------------------------------------------------------------
module nfst_table (
    input  logic                aclk,
    input  logic                aresetn,
    input  nfst_pkg::tbl_req_t  req,
    output nfst_pkg::tbl_stat_t stat
);

    logic [nfst_pkg::HANDLE_W-1:0]   mem [nfst_pkg::SLOT_COUNT];
    logic [nfst_pkg::HANDLE_W-1:0]   rd_data_reg;
    logic [nfst_pkg::SLOT_COUNT-1:0] valid_reg;
    logic [nfst_pkg::SLOT_COUNT-1:0] valid_next;
    logic [nfst_pkg::CNT_W-1:0]      occ_reg;
    logic [nfst_pkg::CNT_W-1:0]      occ_next;

    // Handle memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (req.set_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    // Occupied flags and count. A slot that was never written is empty.
    always_comb begin
        valid_next = valid_reg;
        occ_next   = occ_reg;
        if (req.set_en && !valid_reg[req.wr_addr]) begin
            valid_next[req.wr_addr] = 1'b1;
            occ_next                = occ_reg + nfst_pkg::CNT_W'(1);
        end
        if (req.clr_en && valid_reg[req.wr_addr]) begin
            valid_next[req.wr_addr] = 1'b0;
            occ_next                = occ_reg - nfst_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            occ_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            occ_reg   <= occ_next;
        end
    end

    assign stat.rd_data = rd_data_reg;
    assign stat.valid   = valid_reg;
    assign stat.occ     = occ_reg;

    // The count always matches the number of occupied flags.
    a_occ_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(occ_reg) == $countones(valid_reg))
        else $error("occupancy count differs from occupied flags");

    // Set and clear are never requested in the same cycle.
    a_one_write: assert property (@(posedge aclk) disable iff (!aresetn)
        !(req.set_en && req.clr_en))
        else $error("set and clear requested together");

    // A store only ever lands in an empty slot.
    a_set_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        req.set_en |-> !valid_reg[req.wr_addr])
        else $error("handle stored into an occupied slot");

endmodule
